@@ hw/rtl/mdio_pkg.sv @@
// Shared types and constants for the MDIO management master.
// Used by mdio_front, mdio_queue, mdio_back and mdio_management_master.
`default_nettype none

package mdio_pkg;

  localparam int PREAMBLE_BITS = 32;

  localparam int IDX_W = 7;
  localparam int PHY_W = 5;
  localparam int REG_W = 5;
  localparam int DATA_W = 16;
  localparam int FIELDS_W = PHY_W + REG_W + DATA_W;

  localparam int IN_TDATA_W = 32;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 24;

  // Request kinds on the input stream
  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Operations handed from the front to the back
  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]        code;
    logic [PHY_W-1:0]  phy_addr;
    logic [REG_W-1:0]  reg_addr;
    logic [DATA_W-1:0] write_data;
    logic              mdi;
  } op_t;

  typedef struct packed {
    logic              rejected;
    logic [DATA_W-1:0] read_data;
    logic              done_res;
    logic              busy_res;
    logic              mdoe;
    logic              mdo;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/mdio_front.sv @@
// Front end: unpacks an input transfer and classifies it into an operation.
// Depends on mdio_pkg.
`default_nettype none

module mdio_front import mdio_pkg::*; (
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [IN_TUSER_W-1:0] in_tuser,
  output op_t                        op
);

  always_comb begin
    op.phy_addr   = in_tdata[4:0];
    op.reg_addr   = in_tdata[9:5];
    op.write_data = in_tdata[25:10];
    op.mdi        = in_tdata[26];
    case (in_tuser)
      KIND_READ:  op.code = OP_READ;
      KIND_WRITE: op.code = OP_WRITE;
      KIND_TICK:  op.code = OP_TICK;
      default:    op.code = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/mdio_queue.sv @@
// Two-entry operation queue between front and back.
// Depends on mdio_pkg.
`default_nettype none

module mdio_queue import mdio_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output op_t       pop_op,
  output logic      not_empty
);

  op_t        entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_op    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mdio_back.sv @@
// Back end: frame sequencer for clause 22 transactions plus the result register.
// Depends on mdio_pkg.
`default_nettype none

module mdio_back import mdio_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire op_t  op,
  input  wire logic op_valid,
  output logic      op_pop,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_ready
);

  localparam logic [IDX_W-1:0] PRE = IDX_W'(PREAMBLE_BITS);

  logic                active_r, active_nxt;
  logic                is_write_r, is_write_nxt;
  logic [IDX_W-1:0]    bit_idx_r, bit_idx_nxt;
  logic [FIELDS_W-1:0] fields_r, fields_nxt;
  logic [DATA_W-1:0]   in_shift_r, in_shift_nxt;
  logic                res_valid_r, res_valid_nxt;
  res_t                res_r, res_nxt;

  logic [IDX_W-1:0]    r;
  logic [IDX_W-1:0]    last;
  logic [IDX_W-1:0]    hdr_sel;
  logic [IDX_W-1:0]    dat_sel;
  logic                advance;

  assign advance   = !res_valid_r || res_ready;
  assign op_pop    = op_valid && advance;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    active_nxt    = active_r;
    is_write_nxt  = is_write_r;
    bit_idx_nxt   = bit_idx_r;
    fields_nxt    = fields_r;
    in_shift_nxt  = in_shift_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt       = res_r;

    r       = bit_idx_r - PRE;
    last    = PRE + (is_write_r ? IDX_W'(32) : IDX_W'(31));
    hdr_sel = IDX_W'(29) - r;
    dat_sel = IDX_W'(31) - r;

    if (op_pop) begin
      res_valid_nxt = 1'b1;
      res_nxt       = '0;
      case (op.code)
        OP_READ, OP_WRITE: begin
          if (active_r) begin
            res_nxt.rejected = 1'b1;
          end else begin
            active_nxt   = 1'b1;
            is_write_nxt = (op.code == OP_WRITE);
            bit_idx_nxt  = '0;
            fields_nxt   = {op.phy_addr, op.reg_addr, op.write_data};
            in_shift_nxt = '0;
          end
        end
        OP_TICK: begin
          if (active_r) begin
            if (bit_idx_r < PRE) begin
              res_nxt.mdoe = 1'b1;
              res_nxt.mdo  = 1'b1;
            end else if (r == IDX_W'(0)) begin
              res_nxt.mdoe = 1'b1;
            end else if (r == IDX_W'(1)) begin
              res_nxt.mdoe = 1'b1;
              res_nxt.mdo  = 1'b1;
            end else if (r == IDX_W'(2)) begin
              res_nxt.mdoe = 1'b1;
              res_nxt.mdo  = !is_write_r;
            end else if (r == IDX_W'(3)) begin
              res_nxt.mdoe = 1'b1;
              res_nxt.mdo  = is_write_r;
            end else if (r <= IDX_W'(13)) begin
              // PHY address then register number, MSB first
              res_nxt.mdoe = 1'b1;
              res_nxt.mdo  = fields_r[hdr_sel[4:0]];
            end else if (!is_write_r) begin
              if (r >= IDX_W'(15) && r <= IDX_W'(30)) begin
                in_shift_nxt = {in_shift_r[DATA_W-2:0], op.mdi};
              end
            end else if (r >= IDX_W'(16) && r <= IDX_W'(31)) begin
              res_nxt.mdoe = 1'b1;
              res_nxt.mdo  = fields_r[dat_sel[4:0]];
            end

            if (bit_idx_r >= last) begin
              res_nxt.done_res = 1'b1;
              if (!is_write_r) begin
                res_nxt.read_data = in_shift_r;
              end
              active_nxt  = 1'b0;
              bit_idx_nxt = '0;
            end else begin
              bit_idx_nxt = bit_idx_r + IDX_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
      res_nxt.busy_res = active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      is_write_r  <= 1'b0;
      bit_idx_r   <= '0;
      fields_r    <= '0;
      in_shift_r  <= '0;
      res_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      is_write_r  <= is_write_nxt;
      bit_idx_r   <= bit_idx_nxt;
      fields_r    <= fields_nxt;
      in_shift_r  <= in_shift_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/mdio_management_master.sv @@
// MDIO clause 22 management master: frames PHY register reads and writes.
// An accepted transfer is held in the queue, then its result in the result register.
// Throughput: one transfer per cycle while the output is not stalled; the two-entry queue
//   and the result register let input and output stall independently.
// Reset: rst_n synchronous, active low; clears the sequencer and empties queue and output.
// Depends on mdio_pkg, mdio_front, mdio_queue, mdio_back.
`default_nettype none

module mdio_management_master import mdio_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [4:0] phy_addr, [9:5] reg_addr, [25:10] write_data, [26] mdi, rest zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [0] mdo, [1] mdoe, [2] busy_res, [3] done_res, [19:4] read_data,
  // [20] rejected, rest zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  op_t  front_op;
  op_t  queue_op;
  logic queue_full;
  logic queue_not_empty;
  logic queue_pop;
  res_t res;

  // Accept whenever the queue has room
  assign in_tready = !queue_full;

  mdio_front u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .op       (front_op)
  );

  mdio_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_op   (front_op),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_op    (queue_op),
    .not_empty (queue_not_empty)
  );

  mdio_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (queue_op),
    .op_valid  (queue_not_empty),
    .op_pop    (queue_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  // Pack the result with mdo in the lowest bit, pad to whole bytes
  assign out_tdata = {3'b000, res.rejected, res.read_data, res.done_res,
                      res.busy_res, res.mdoe, res.mdo};

endmodule

`default_nettype wire

@@ dv/mdio_management_master_tb.sv @@
// Self-checking testbench for the MDIO clause 22 management master.
// Drives request and bit-time transfers, predicts every result in place and checks it.
// Depends on mdio_pkg and mdio_management_master.
`timescale 1ns / 100ps

module mdio_management_master_tb;
  import mdio_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int ITEM_TARGET = 900;
  localparam int FRAME_PREAMBLE = PREAMBLE_BITS;
  localparam int READ_TICKS = FRAME_PREAMBLE + 32;
  localparam int WRITE_TICKS = FRAME_PREAMBLE + 33;
  localparam int LONG_HOLD_AT = 120;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 10;
  localparam longint TIMEOUT_NS = 4_000_000;

  // Kind code outside the defined set; the block must treat it as a no-op that leaves the frame as it is
  localparam logic [1:0] KIND_UNDEF = 2'd3;

  // Line patterns for the data bits sampled during a read
  localparam int MDI_RANDOM = 0;
  localparam int MDI_ZEROS = 1;
  localparam int MDI_ONES = 2;

  typedef struct {
    logic [1:0]  kind;
    logic [4:0]  phy_addr;
    logic [4:0]  reg_addr;
    logic [15:0] write_data;
    logic        mdi;
    logic        drain_first;
  } mdio_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  mdio_item_t pending_items[$];
  res_t       expected_results[$];
  mdio_item_t cur_item;
  int         total_items = 0;
  int         accepted_items = 0;
  int         results_seen = 0;
  int         mismatch_count = 0;
  int         rx_hold_left = 0;
  logic       rx_hold_taken = 1'b0;

  // Mirror of the sequencer state
  logic        seq_active = 1'b0;
  logic        seq_is_write = 1'b0;
  logic [6:0]  seq_bit_index = '0;
  logic [25:0] seq_fields = '0;
  logic [15:0] seq_in_shift = '0;

  mdio_management_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // Advance the sequencer by one transfer and return the line state it yields
  function automatic res_t predict_frame_step(input mdio_item_t it);
    res_t r;
    int   idx;
    int   rel;
    int   last_idx;
    r = '0;
    if (it.kind == KIND_READ || it.kind == KIND_WRITE) begin
      if (seq_active) begin
        r.rejected = 1'b1;
      end else begin
        seq_active = 1'b1;
        seq_is_write = (it.kind == KIND_WRITE);
        seq_bit_index = '0;
        seq_fields = {it.phy_addr, it.reg_addr, it.write_data};
        seq_in_shift = '0;
      end
    end else if (it.kind == KIND_TICK && seq_active) begin
      idx = int'(seq_bit_index);
      last_idx = (seq_is_write ? WRITE_TICKS : READ_TICKS) - 1;
      if (idx < FRAME_PREAMBLE) begin
        r.mdoe = 1'b1;
        r.mdo = 1'b1;
      end else begin
        rel = idx - FRAME_PREAMBLE;
        if (rel <= 13) begin
          r.mdoe = 1'b1;
          case (rel)
            0: r.mdo = 1'b0;
            1: r.mdo = 1'b1;
            2: r.mdo = ~seq_is_write;
            3: r.mdo = seq_is_write;
            default: begin
              // address fields go out MSB first
              if (rel <= 8) r.mdo = seq_fields[21 + 8 - rel];
              else r.mdo = seq_fields[16 + 13 - rel];
            end
          endcase
        end else if (!seq_is_write) begin
          if (rel >= 15 && rel <= 30) seq_in_shift = {seq_in_shift[14:0], it.mdi};
        end else if (rel >= 16 && rel <= 31) begin
          r.mdoe = 1'b1;
          r.mdo = seq_fields[31 - rel];
        end
      end
      if (idx >= last_idx) begin
        r.done_res = 1'b1;
        if (!seq_is_write) r.read_data = seq_in_shift;
        seq_active = 1'b0;
        seq_bit_index = '0;
      end else begin
        seq_bit_index = 7'(idx + 1);
      end
    end
    r.busy_res = seq_active;
    return r;
  endfunction

  function automatic int tx_idle_pct();
    if (accepted_items < total_items / 3) return 23;
    if (accepted_items < 2 * total_items / 3) return 64;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (accepted_items < total_items / 3) return 64;
    if (accepted_items < 2 * total_items / 3) return 23;
    return 0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h", $time, results_seen, what,
             got, want);
    mismatch_count++;
  endtask

  task automatic push_item(input logic [1:0] kind, input logic [4:0] pa, input logic [4:0] ra,
                           input logic [15:0] wd, input logic mdi);
    mdio_item_t it;
    it.kind = kind;
    it.phy_addr = pa;
    it.reg_addr = ra;
    it.write_data = wd;
    it.mdi = mdi;
    it.drain_first = 1'b0;
    pending_items.push_back(it);
  endtask

  task automatic push_noise(input logic [1:0] kind);
    push_item(kind, 5'($urandom_range(31)), 5'($urandom_range(31)),
              16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
  endtask

  // Queue the bit-times of a running frame; busy_pct mixes in refused requests and bad kinds
  task automatic push_ticks(input int n_ticks, input int mdi_mode, input int busy_pct);
    logic mdi;
    for (int i = 0; i < n_ticks; i++) begin
      if ($urandom_range(99) < busy_pct) begin
        case ($urandom_range(2))
          0: push_noise(KIND_READ);
          1: push_noise(KIND_WRITE);
          default: push_noise(KIND_UNDEF);
        endcase
      end
      case (mdi_mode)
        MDI_ZEROS: mdi = 1'b0;
        MDI_ONES: mdi = 1'b1;
        default: mdi = 1'($urandom_range(1));
      endcase
      push_item(KIND_TICK, 5'($urandom_range(31)), 5'($urandom_range(31)),
                16'($urandom_range(16'hFFFF)), mdi);
    end
  endtask

  task automatic push_frame(input logic [1:0] kind, input logic [4:0] pa, input logic [4:0] ra,
                            input logic [15:0] wd, input int mdi_mode, input int busy_pct);
    push_item(kind, pa, ra, wd, 1'($urandom_range(1)));
    push_ticks(kind == KIND_WRITE ? WRITE_TICKS : READ_TICKS, mdi_mode, busy_pct);
  endtask

  // Driver: predict on every accepted transfer, then offer the next pending item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_frame_step(cur_item));
        accepted_items <= accepted_items + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 &&
            !(pending_items[0].drain_first && expected_results.size() != 0) &&
            $urandom_range(99) >= tx_idle_pct()) begin
          cur_item = pending_items.pop_front();
          in_tdata <= {5'b0, cur_item.mdi, cur_item.write_data, cur_item.reg_addr,
                       cur_item.phy_addr};
          in_tuser <= cur_item.kind;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off to fill the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready <= 1'b0;
    end else if (!rx_hold_taken && accepted_items >= LONG_HOLD_AT) begin
      rx_hold_taken <= 1'b1;
      rx_hold_left <= LONG_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct());
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[20:0]);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", int'(out_tdata), 0);
      end else begin
        want = expected_results.pop_front();
        if (got.mdo !== want.mdo)
          report_mismatch("mdo", int'(got.mdo), int'(want.mdo));
        if (got.mdoe !== want.mdoe)
          report_mismatch("mdoe", int'(got.mdoe), int'(want.mdoe));
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy", int'(got.busy_res), int'(want.busy_res));
        if (got.done_res !== want.done_res)
          report_mismatch("done", int'(got.done_res), int'(want.done_res));
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", int'(got.read_data), int'(want.read_data));
        if (got.rejected !== want.rejected)
          report_mismatch("rejected", int'(got.rejected), int'(want.rejected));
        if (out_tdata[OUT_TDATA_W-1:21] !== '0)
          report_mismatch("padding", int'(out_tdata[OUT_TDATA_W-1:21]), 0);
      end
      results_seen++;
    end
  end

  initial begin
    // Directed: idle ticks, an unknown kind, a read with refusals and a bad kind mid-frame
    push_item(KIND_TICK, 5'd31, 5'd31, 16'hFFFF, 1'b1);
    push_item(KIND_TICK, 5'd0, 5'd0, 16'h0000, 1'b0);
    push_item(KIND_UNDEF, 5'd31, 5'd0, 16'hFFFF, 1'b1);
    push_item(KIND_READ, 5'd31, 5'd0, 16'hFFFF, 1'b0);
    push_item(KIND_WRITE, 5'd0, 5'd31, 16'h0000, 1'b1);
    push_item(KIND_READ, 5'd21, 5'd10, 16'hA5A5, 1'b0);
    push_item(KIND_UNDEF, 5'd0, 5'd0, 16'h0000, 1'b0);
    push_ticks(READ_TICKS, MDI_ONES, 0);
    // Back-to-back frames at the field extremes
    push_frame(KIND_WRITE, 5'd0, 5'd31, 16'h0000, MDI_ONES, 0);
    push_frame(KIND_WRITE, 5'd31, 5'd0, 16'hFFFF, MDI_ZEROS, 0);
    push_frame(KIND_READ, 5'd0, 5'd31, 16'h5A5A, MDI_ZEROS, 0);
    push_item(KIND_TICK, 5'd10, 5'd21, 16'h1234, 1'b1);

    // Random: mostly whole frames with random content, some idle noise between them
    while (pending_items.size() < ITEM_TARGET) begin
      repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0)
        push_noise($urandom_range(1) ? KIND_TICK : KIND_UNDEF);
      push_frame($urandom_range(1) ? KIND_WRITE : KIND_READ, 5'($urandom_range(31)),
                 5'($urandom_range(31)), 16'($urandom_range(16'hFFFF)),
                 $urandom_range(9) == 0 ? $urandom_range(MDI_ZEROS, MDI_ONES) : MDI_RANDOM,
                 $urandom_range(1) ? 4 : 0);
    end
    total_items = pending_items.size();
    // Hold the sender until everything has drained, twice in the run
    pending_items[total_items / 3].drain_first = 1'b1;
    pending_items[2 * total_items / 3].drain_first = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_items != total_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mdio_pkg.sv
hw/rtl/mdio_front.sv
hw/rtl/mdio_queue.sv
hw/rtl/mdio_back.sv
hw/rtl/mdio_management_master.sv
dv/mdio_management_master_tb.sv
